### rtl/urbc_pkg.sv
// Package: widths, constants, bias tables and log fraction table for range bias correction.
`default_nettype none
package urbc_pkg;
  localparam int LOG_FRACTION_BITS_DEF = 8;
  localparam int BIAS_POINTS_DEF = 18;
  localparam int TS_W = 40;
  localparam int CIR_W = 16;
  localparam int CNT_W = 13;
  localparam int BIAS_W = 10;
  localparam int PWR_W = 17;
  localparam int TPM_W = 16;
  localparam int IDX_W = 2;

  localparam logic [IDX_W-1:0] REG_WIDE_BAND = 2'd0;
  localparam logic [IDX_W-1:0] REG_PRF_64 = 2'd1;
  localparam logic [IDX_W-1:0] REG_TICKS_PER_MM = 2'd2;
  localparam logic [TPM_W-1:0] TICKS_PER_MM_RESET = 16'd13969;

  localparam logic signed [PWR_W-1:0] POWER_MAX_Q8 = 17'sd12800;
  localparam logic signed [PWR_W-1:0] POWER_MIN_Q8 = -17'sd51200;
  localparam int KNEE_Q8 = 22528;
  localparam int BASE_Q8 = 15616;
  localparam int TENLOG2_Q16 = 197283;
  localparam int OFS_16 = 29624;
  localparam int OFS_64 = 31165;
  localparam int SLOPE_16 = 152922;
  localparam int SLOPE_64 = 76461;

  // Fraction table entry: repeated squaring, one result bit per step.
  function automatic int log_entry(input int idx, input int lfb);
    logic [63:0] x;
    int r;
    begin
      x = 64'((64'(1) << lfb) + 64'(idx)) << (31 - lfb);
      r = 0;
      for (int k = 0; k < lfb + 4; k++) begin
        x = (x * x) >> 31;
        r = r << 1;
        if (x >= (64'd1 << 32)) begin
          r = r | 1;
          x = x >> 1;
        end
      end
      return (r + 8) >> 4;
    end
  endfunction

  // Signed bias table value in mm; sel = {wide_band, prf_64}.
  function automatic logic signed [9:0] bias_rom(input logic [1:0] sel, input logic [4:0] i);
    logic signed [9:0] v;
    begin
      v = '0;
      unique case (sel)
        2'b00: begin
          unique case (i)
            5'd0: v = -10'sd198; 5'd1: v = -10'sd187; 5'd2: v = -10'sd179;
            5'd3: v = -10'sd163; 5'd4: v = -10'sd143; 5'd5: v = -10'sd127;
            5'd6: v = -10'sd109; 5'd7: v = -10'sd84; 5'd8: v = -10'sd59;
            5'd9: v = -10'sd31; 5'd10: v = 10'sd0; 5'd11: v = 10'sd36;
            5'd12: v = 10'sd65; 5'd13: v = 10'sd84; 5'd14: v = 10'sd97;
            5'd15: v = 10'sd106; 5'd16: v = 10'sd110; default: v = 10'sd112;
          endcase
        end
        2'b01: begin
          unique case (i)
            5'd0: v = -10'sd110; 5'd1: v = -10'sd105; 5'd2: v = -10'sd100;
            5'd3: v = -10'sd93; 5'd4: v = -10'sd82; 5'd5: v = -10'sd69;
            5'd6: v = -10'sd51; 5'd7: v = -10'sd27; 5'd8: v = 10'sd0;
            5'd9: v = 10'sd21; 5'd10: v = 10'sd35; 5'd11: v = 10'sd42;
            5'd12: v = 10'sd49; 5'd13: v = 10'sd62; 5'd14: v = 10'sd71;
            5'd15: v = 10'sd76; 5'd16: v = 10'sd81; default: v = 10'sd86;
          endcase
        end
        2'b10: begin
          unique case (i)
            5'd0: v = -10'sd274; 5'd1: v = -10'sd244; 5'd2: v = -10'sd210;
            5'd3: v = -10'sd176; 5'd4: v = -10'sd138; 5'd5: v = -10'sd94;
            5'd6: v = -10'sd50; 5'd7: v = 10'sd0; 5'd8: v = 10'sd42;
            5'd9: v = 10'sd96; 5'd10: v = 10'sd158; 5'd11: v = 10'sd210;
            5'd12: v = 10'sd254; 5'd13: v = 10'sd294; 5'd14: v = 10'sd320;
            5'd15: v = 10'sd338; 5'd16: v = 10'sd356; default: v = 10'sd394;
          endcase
        end
        default: begin
          unique case (i)
            5'd0: v = -10'sd294; 5'd1: v = -10'sd266; 5'd2: v = -10'sd234;
            5'd3: v = -10'sd198; 5'd4: v = -10'sd150; 5'd5: v = -10'sd100;
            5'd6: v = -10'sd58; 5'd7: v = 10'sd0; 5'd8: v = 10'sd48;
            5'd9: v = 10'sd90; 5'd10: v = 10'sd126; 5'd11: v = 10'sd152;
            5'd12: v = 10'sd174; 5'd13: v = 10'sd196; 5'd14: v = 10'sd232;
            5'd15: v = 10'sd244; 5'd16: v = 10'sd264; default: v = 10'sd284;
          endcase
        end
      endcase
      return v;
    end
  endfunction
endpackage
`default_nettype wire

### rtl/urbc_log2.sv
// Registered log2 unit: leading-one encoder plus fraction table lookup.
`default_nettype none
module urbc_log2 #(
  parameter int W = 16,
  parameter int LFB = urbc_pkg::LOG_FRACTION_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic [W-1:0]      v,
  output logic [$clog2(W)+LFB-1:0] lg
);
  localparam int EW = $clog2(W);
  localparam int TN = 1 << LFB;

  logic [LFB-1:0] rom [TN];
  logic [EW-1:0]  e;
  logic [W+LFB-1:0] vs;
  logic [LFB-1:0] idx;

  // Fraction table, built at elaboration.
  always_comb begin
    for (int i = 0; i < TN; i++) begin
      rom[i] = LFB'(urbc_pkg::log_entry(i, LFB));
    end
  end

  // MSB position and following mantissa bits.
  always_comb begin
    e = '0;
    for (int i = 1; i < W; i++) begin
      if (v[i]) e = EW'(i);
    end
    vs = {v, {LFB{1'b0}}} >> e;
    idx = vs[LFB-1:0];
  end

  always_ff @(posedge clk) begin
    lg <= {e, {LFB{1'b0}}} + {{EW{1'b0}}, rom[idx]};
  end
endmodule
`default_nettype wire

### rtl/urbc_power.sv
// Receive power pipeline: log difference, dB scaling, offset and knee correction.
`default_nettype none
module urbc_power #(
  parameter int LFB = urbc_pkg::LOG_FRACTION_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic prf_64,
  input  wire logic [urbc_pkg::CIR_W-1:0] cir_growth,
  input  wire logic [urbc_pkg::CNT_W-1:0] preamble_count,
  output logic signed [urbc_pkg::PWR_W-1:0] power
);
  localparam int LCW = 4 + LFB;
  localparam int LNW = 4 + LFB;
  localparam int LGW = LFB + 8;
  localparam int TENLOG2_C = urbc_pkg::TENLOG2_Q16;

  logic [LCW-1:0] lc;
  logic [LNW-1:0] ln;
  logic zc1, zc2, zc3, zc4, zc5;
  logic signed [LGW-1:0] lg2;
  logic signed [LGW+19:0] prod3;
  logic signed [23:0] p4;
  logic signed [23:0] p_q;
  logic signed [41:0] kprod;
  logic signed [23:0] p5;
  logic signed [41:0] knee;

  urbc_log2 #(.W(urbc_pkg::CIR_W), .LFB(LFB)) u_lc (.clk(clk), .v(cir_growth), .lg(lc));
  urbc_log2 #(.W(urbc_pkg::CNT_W), .LFB(LFB)) u_ln (
    .clk(clk), .v(preamble_count), .lg(ln[LNW-1:0]));

  // Stage 2: log difference; stage 3: dB scale; stage 4: offset; stage 5: knee.
  always_ff @(posedge clk) begin
    zc1 <= (cir_growth == '0);
    zc2 <= zc1;
    lg2 <= LGW'(signed'({1'b0, lc})) + LGW'(17 << LFB) - LGW'(signed'({1'b0, ln, 1'b0}));
    zc3 <= zc2;
    prod3 <= (LGW+20)'(lg2) * (LGW+20)'(TENLOG2_C) + (LGW+20)'(1 << (LFB + 7));
    zc4 <= zc3;
    p4 <= 24'(prod3 >>> (LFB + 8)) - (prf_64 ? 24'(urbc_pkg::OFS_64) : 24'(urbc_pkg::OFS_16));
    zc5 <= zc4;
    p5 <= p4;
    kprod <= 42'(p4 + 24'(urbc_pkg::KNEE_Q8)) *
             (prf_64 ? 42'(urbc_pkg::SLOPE_64) : 42'(urbc_pkg::SLOPE_16)) + 42'(32768);
  end

  // Knee add and saturation.
  always_comb begin
    knee = kprod >>> 16;
    p_q = p5;
    if (p5 > -24'(urbc_pkg::KNEE_Q8)) p_q = p5 + 24'(knee);
    if (zc5 || p_q < 24'(urbc_pkg::POWER_MIN_Q8)) power = urbc_pkg::POWER_MIN_Q8;
    else if (p_q > 24'(urbc_pkg::POWER_MAX_Q8)) power = urbc_pkg::POWER_MAX_Q8;
    else power = p_q[urbc_pkg::PWR_W-1:0];
  end
endmodule
`default_nettype wire

### rtl/uwb_range_bias_correction.sv
// Top level: receive-power-based range bias correction of UWB timestamps.
//
// Usage: pulse start for one cycle with raw_timestamp, cir_growth and
// preamble_count; busy is always low, so a transfer can be offered every
// cycle. Each transfer yields exactly one result, shown on
// corrected_timestamp, bias_mm, rx_power_q8 and bad_count for one cycle
// with done high. Throughput is one item per cycle; the pipeline depth
// is set by the two log lookups, the dB-scale multiply, the knee multiply,
// interpolation and tick scaling.
// The receiver cannot stall; results must be taken when done is high.
// The user must write configuration (wr_en, wr_index, wr_data) only while
// idle; the block does not enforce it. Index 0 wide_band, 1 prf_64, 2
// ticks_per_mm; others are ignored. Reset (rst, synchronous) clears all
// valid bits and restores register defaults; items in flight are dropped.
`default_nettype none
module uwb_range_bias_correction #(
  parameter int LOG_FRACTION_BITS = urbc_pkg::LOG_FRACTION_BITS_DEF,
  parameter int BIAS_POINTS = urbc_pkg::BIAS_POINTS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  output logic busy,
  input  wire logic [urbc_pkg::TS_W-1:0] raw_timestamp,
  input  wire logic [urbc_pkg::CIR_W-1:0] cir_growth,
  input  wire logic [urbc_pkg::CNT_W-1:0] preamble_count,
  input  wire logic wr_en,
  input  wire logic [urbc_pkg::IDX_W-1:0] wr_index,
  input  wire logic [urbc_pkg::TPM_W-1:0] wr_data,
  output logic done,
  output logic [urbc_pkg::TS_W-1:0] corrected_timestamp,
  output logic signed [urbc_pkg::BIAS_W-1:0] bias_mm,
  output logic signed [urbc_pkg::PWR_W-1:0] rx_power_q8,
  output logic bad_count
);
  localparam int D = 9;
  localparam int PD = 5;

  logic wide_band, prf_64;
  logic [urbc_pkg::TPM_W-1:0] ticks_per_mm;
  logic [D-1:0] vld;
  logic [urbc_pkg::TS_W-1:0] ts [D];
  logic bad [D];
  logic signed [urbc_pkg::PWR_W-1:0] pw [PD:D-1];
  logic signed [urbc_pkg::PWR_W-1:0] power;

  // Stage 6 index/fraction, 7 table, 8 interpolation, 9 tick scale.
  logic signed [18:0] b;
  logic [4:0] lo6, hi6;
  logic [8:0] f6;
  logic signed [9:0] tlo7, thi7;
  logic [8:0] f7;
  logic signed [20:0] bn8;
  logic signed [38:0] tk9;
  logic signed [20:0] bn9;

  assign busy = 1'b0;

  urbc_power #(.LFB(LOG_FRACTION_BITS)) u_pwr (
    .clk(clk), .prf_64(prf_64), .cir_growth(cir_growth),
    .preamble_count(preamble_count), .power(power));

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      wide_band <= 1'b0;
      prf_64 <= 1'b0;
      ticks_per_mm <= urbc_pkg::TICKS_PER_MM_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        urbc_pkg::REG_WIDE_BAND: wide_band <= wr_data[0];
        urbc_pkg::REG_PRF_64: prf_64 <= wr_data[0];
        urbc_pkg::REG_TICKS_PER_MM: ticks_per_mm <= wr_data;
        default: ;
      endcase
    end
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else vld <= {vld[D-2:0], start & ~busy};
  end

  // Payload that rides along.
  always_ff @(posedge clk) begin
    ts[0] <= raw_timestamp;
    bad[0] <= (preamble_count == '0);
    for (int i = 1; i < D; i++) begin
      ts[i] <= ts[i-1];
      bad[i] <= bad[i-1];
    end
    pw[PD] <= power;
    for (int i = PD + 1; i < D; i++) pw[i] <= pw[i-1];
  end

  // Table position from power.
  assign b = -(19'(power) + 19'(urbc_pkg::BASE_Q8));

  always_ff @(posedge clk) begin
    if (b < 0) begin
      lo6 <= '0; hi6 <= '0; f6 <= '0;
    end else if (b[18:9] >= 10'(BIAS_POINTS - 1)) begin
      lo6 <= 5'(BIAS_POINTS - 1); hi6 <= 5'(BIAS_POINTS - 1); f6 <= '0;
    end else begin
      lo6 <= b[13:9]; hi6 <= b[13:9] + 5'd1; f6 <= b[8:0];
    end
    tlo7 <= urbc_pkg::bias_rom({wide_band, prf_64}, lo6);
    thi7 <= urbc_pkg::bias_rom({wide_band, prf_64}, hi6);
    f7 <= f6;
    bn8 <= (21'(tlo7) <<< 9) + 21'(signed'({1'b0, f7})) * (21'(thi7) - 21'(tlo7));
    bn9 <= bn8;
    tk9 <= 39'(bn8) * 39'(signed'({1'b0, ticks_per_mm}));
  end

  // Truncating divides toward zero and output drive.
  logic signed [20:0] bmm;
  logic signed [38:0] tk;
  always_comb begin
    bmm = (bn9 < 0) ? -((-bn9) >>> 9) : (bn9 >>> 9);
    tk = (tk9 < 0) ? -((-tk9) >>> 25) : (tk9 >>> 25);
    done = vld[D-1];
    bad_count = bad[D-1];
    if (bad[D-1]) begin
      corrected_timestamp = ts[D-1];
      bias_mm = '0;
      rx_power_q8 = '0;
    end else begin
      corrected_timestamp = ts[D-1] + urbc_pkg::TS_W'(tk);
      bias_mm = bmm[urbc_pkg::BIAS_W-1:0];
      rx_power_q8 = pw[D-1];
    end
  end

`ifndef SYNTHESIS
  a_lat: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##9 done) else $error("result missing");
  a_bad: assert property (@(posedge clk) disable iff (rst)
    (done && bad_count) |-> (bias_mm == '0 && rx_power_q8 == '0)) else $error("bad item");
  a_pwr: assert property (@(posedge clk) disable iff (rst)
    done |-> (rx_power_q8 <= urbc_pkg::POWER_MAX_Q8)) else $error("power range");
`endif
endmodule
`default_nettype wire

### tb/sv/tb_top.sv
// Testbench for uwb_range_bias_correction: directed and random frames checked against a predictor.
`timescale 1ns / 100ps
module tb_top;
  localparam int STALL_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 20;

  typedef struct packed {
    logic [urbc_pkg::TS_W-1:0] ts;
    logic signed [urbc_pkg::BIAS_W-1:0] bias;
    logic signed [urbc_pkg::PWR_W-1:0] pwr;
    logic bad;
  } corr_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [urbc_pkg::TS_W-1:0] raw_timestamp = '0;
  logic [urbc_pkg::CIR_W-1:0] cir_growth = '0;
  logic [urbc_pkg::CNT_W-1:0] preamble_count = '0;
  logic wr_en = 1'b0;
  logic [urbc_pkg::IDX_W-1:0] wr_index = '0;
  logic [urbc_pkg::TPM_W-1:0] wr_data = '0;
  logic done;
  logic [urbc_pkg::TS_W-1:0] corrected_timestamp;
  logic signed [urbc_pkg::BIAS_W-1:0] bias_mm;
  logic signed [urbc_pkg::PWR_W-1:0] rx_power_q8;
  logic bad_count;

  // predictor copy of the registers
  logic cfg_wide = 1'b0;
  logic cfg_prf = 1'b0;
  logic [urbc_pkg::TPM_W-1:0] cfg_tpm = urbc_pkg::TICKS_PER_MM_RESET;

  corr_t pending_corr[$];
  int errors = 0;
  int stall_cycles = 0;
  bit no_gaps = 1'b0;
  int log_frac[256];

  int bias_n16[18] = '{-198, -187, -179, -163, -143, -127, -109, -84, -59, -31, 0, 36, 65,
                       84, 97, 106, 110, 112};
  int bias_n64[18] = '{-110, -105, -100, -93, -82, -69, -51, -27, 0, 21, 35, 42, 49, 62,
                       71, 76, 81, 86};
  int bias_w16[18] = '{-137, -122, -105, -88, -69, -47, -25, 0, 21, 48, 79, 105, 127, 147,
                       160, 169, 178, 197};
  int bias_w64[18] = '{-147, -133, -117, -99, -75, -50, -29, 0, 24, 45, 63, 76, 87, 98,
                       116, 122, 132, 142};

  uwb_range_bias_correction dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .raw_timestamp(raw_timestamp), .cir_growth(cir_growth), .preamble_count(preamble_count),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .done(done), .corrected_timestamp(corrected_timestamp), .bias_mm(bias_mm),
    .rx_power_q8(rx_power_q8), .bad_count(bad_count)
  );

  always #5 clk = ~clk;

  // log2 fraction: square the mantissa, one result bit per step
  function automatic int frac_entry(int i);
    logic [63:0] x;
    int r;
    x = 64'(256 + i) << 23;
    r = 0;
    for (int k = 0; k < 12; k++) begin
      x = (x * x) >> 31;
      r = r << 1;
      if (x >= (64'd1 << 32)) begin
        r = r | 1;
        x = x >> 1;
      end
    end
    return (r + 8) >> 4;
  endfunction

  function automatic longint log2_q8(int v);
    int e;
    int idx;
    e = 0;
    while (e < 31 && (v >> (e + 1)) != 0) e++;
    if (e >= 8) idx = (v >> (e - 8)) & 255;
    else idx = (v << (8 - e)) & 255;
    return longint'(e * 256 + log_frac[idx]);
  endfunction

  function automatic longint power_q8(int c, int n);
    longint lg;
    longint p;
    if (c == 0) return -51200;
    lg = log2_q8(c) + 17 * 256 - 2 * log2_q8(n);
    p = (lg * 197283 + 32768) >>> 16;
    p -= cfg_prf ? 31165 : 29624;
    if (p > -22528) p += ((p + 22528) * (cfg_prf ? 76461 : 152922) + 32768) >>> 16;
    if (p > 12800) p = 12800;
    if (p < -51200) p = -51200;
    return p;
  endfunction

  function automatic longint bias_point(int i);
    int v;
    unique case ({cfg_wide, cfg_prf})
      2'b00: v = bias_n16[i];
      2'b01: v = bias_n64[i];
      2'b10: v = bias_w16[i];
      default: v = bias_w64[i];
    endcase
    return cfg_wide ? 2 * v : v;
  endfunction

  function automatic corr_t correct_frame(logic [urbc_pkg::TS_W-1:0] ts, int c, int n);
    corr_t o;
    longint p, b, bnum, ticks, tlo, thi;
    int lo, hi, f;
    if (n == 0) begin
      o.ts = ts; o.bias = '0; o.pwr = '0; o.bad = 1'b1;
      return o;
    end
    p = power_q8(c, n);
    b = -(p + 15616);
    if (b < 0) begin
      lo = 0; hi = 0; f = 0;
    end else if ((b >>> 9) >= 17) begin
      lo = 17; hi = 17; f = 0;
    end else begin
      lo = int'(b >>> 9); hi = lo + 1; f = int'(b & 511);
    end
    tlo = bias_point(lo);
    thi = bias_point(hi);
    bnum = tlo * 512 + longint'(f) * (thi - tlo);
    ticks = (bnum * longint'(cfg_tpm)) / (longint'(1) << 25);
    o.ts = ts + urbc_pkg::TS_W'(ticks);
    o.bias = urbc_pkg::BIAS_W'(bnum / 512);
    o.pwr = urbc_pkg::PWR_W'(p);
    o.bad = 1'b0;
    return o;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
  endtask

  // check every result against the oldest expectation
  always @(posedge clk) begin
    corr_t w;
    if (!rst && done) begin
      if (pending_corr.size() == 0) begin
        report_mismatch("unexpected result", corrected_timestamp, 0);
      end else begin
        w = pending_corr.pop_front();
        if (corrected_timestamp !== w.ts)
          report_mismatch("corrected_timestamp", corrected_timestamp, w.ts);
        if (bias_mm !== w.bias) report_mismatch("bias_mm", bias_mm, w.bias);
        if (rx_power_q8 !== w.pwr) report_mismatch("rx_power_q8", rx_power_q8, w.pwr);
        if (bad_count !== w.bad) report_mismatch("bad_count", bad_count, w.bad);
      end
    end
  end

  // watchdog on cycles with no transfer on either side
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic idle_gap();
    int r;
    int n;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) n = 0;
    else if (r < 90) n = $urandom_range(1, 3);
    else n = $urandom_range(10, 40);
    if (n > 0) begin
      @(negedge clk);
      start = 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic send_frame(logic [urbc_pkg::TS_W-1:0] ts, int c, int n);
    @(negedge clk);
    while (busy) @(negedge clk);
    start = 1'b1;
    raw_timestamp = ts;
    cir_growth = urbc_pkg::CIR_W'(c);
    preamble_count = urbc_pkg::CNT_W'(n);
    @(posedge clk);
    pending_corr.push_back(correct_frame(ts, c, n));
    idle_gap();
  endtask

  task automatic wait_idle();
    @(negedge clk);
    start = 1'b0;
    while (pending_corr.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [urbc_pkg::IDX_W-1:0] idx, logic [urbc_pkg::TPM_W-1:0] val);
    @(negedge clk);
    wr_en = 1'b1;
    wr_index = idx;
    wr_data = val;
    @(posedge clk);
    unique case (idx)
      urbc_pkg::REG_WIDE_BAND: cfg_wide = val[0];
      urbc_pkg::REG_PRF_64: cfg_prf = val[0];
      urbc_pkg::REG_TICKS_PER_MM: cfg_tpm = val;
      default: ;
    endcase
    @(negedge clk);
    wr_en = 1'b0;
  endtask

  task automatic set_mode(bit wide, bit prf, logic [urbc_pkg::TPM_W-1:0] tpm);
    wait_idle();
    write_reg(urbc_pkg::REG_WIDE_BAND, {15'($urandom), wide});
    write_reg(urbc_pkg::REG_PRF_64, {15'($urandom), prf});
    write_reg(urbc_pkg::REG_TICKS_PER_MM, tpm);
  endtask

  function automatic int rand_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return 0;
    if (r < 15) return $urandom_range(1, 8191);
    if (r < 35) return $urandom_range(1, 64);
    return $urandom_range(1, 4096);
  endfunction

  function automatic int rand_cir();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return 0;
    if (r < 40) return $urandom_range(0, 65535);
    return $urandom_range(1, 1 << $urandom_range(1, 16)) - 1;
  endfunction

  // extremes and special cases under the reset configuration
  task automatic test_directed();
    send_frame('0, 1000, 1024);
    send_frame({urbc_pkg::TS_W{1'b1}}, 1000, 1024);
    send_frame({urbc_pkg::TS_W{1'b1}}, 0, 1024);
    send_frame(40'h12_3456_789A, 1234, 0);
    send_frame({urbc_pkg::TS_W{1'b1}}, 65535, 0);
    send_frame(40'h55_5555_5555, 65535, 1);
    send_frame(40'hAA_AAAA_AAAA, 1, 8191);
    send_frame(40'h00_0000_0100, 1, 4096);
    send_frame(40'h80_0000_0000, 65535, 4096);
    send_frame(40'h7F_FFFF_FFFF, 30000, 1024);
    send_frame(40'h00_0000_0001, 3000, 1024);
    send_frame(40'h00_FFFF_0000, 300, 1024);
    send_frame(40'h01_0000_0000, 255, 16);
    send_frame(40'h10_0000_0000, 256, 8191);
  endtask

  // every bandwidth/PRF pair with extreme and random scale factors
  task automatic test_config_sweep();
    logic [urbc_pkg::TPM_W-1:0] tpm;
    for (int m = 0; m < 8; m++) begin
      case (m % 3)
        0: tpm = 16'hFFFF;
        1: tpm = 16'h0000;
        default: tpm = 16'($urandom);
      endcase
      set_mode(m[0], m[1], tpm);
      // unused register index must not disturb anything
      write_reg(urbc_pkg::IDX_W'(urbc_pkg::REG_TICKS_PER_MM + 1), 16'($urandom));
      send_frame({urbc_pkg::TS_W{1'b1}}, 0, 1);
      send_frame('0, 65535, 1);
      send_frame(40'($urandom) << 8, 4000, 1024);
    end
  endtask

  task automatic test_random();
    for (int m = 0; m < 8; m++) begin
      set_mode($urandom_range(0, 1), $urandom_range(0, 1),
               m == 0 ? urbc_pkg::TICKS_PER_MM_RESET : 16'($urandom));
      no_gaps = (m % 3 == 2);
      for (int i = 0; i < 110; i++)
        send_frame({8'($urandom), 32'($urandom)}, rand_cir(), rand_count());
      no_gaps = 1'b0;
    end
  endtask

  // sender holds off until the pipeline has drained, then resumes
  task automatic test_drain_pause();
    for (int i = 0; i < 12; i++) send_frame({8'($urandom), 32'($urandom)}, rand_cir(), rand_count());
    wait_idle();
    for (int i = 0; i < 12; i++) send_frame({8'($urandom), 32'($urandom)}, rand_cir(), rand_count());
  endtask

  initial begin
    for (int i = 0; i < 256; i++) log_frac[i] = frac_entry(i);
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_config_sweep();
    test_random();
    test_drain_pause();
    wait_idle();
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
